// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; both sample on clk and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every active clock edge.
`define PKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Check that the consequent holds whenever the antecedent holds.
`define PKD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pkd_pkg.sv -----
package pkd_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int INDEX_BITS_DEFAULT  = 16;

  localparam int FIELD_BITS     = 16;
  localparam int COUNT_BITS     = 15;
  localparam int KIND_EN_BITS   = 3;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 15;

  localparam logic [COUNT_BITS-1:0]   COUNT_MAX         = 15'h7fff;
  localparam logic [KIND_EN_BITS-1:0] KIND_ENABLE_RESET = 3'd7;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_KIND_ENABLE     = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RECORD_CAPACITY = 1'd1;

  localparam int EN_MAX  = 0;
  localparam int EN_MIN  = 1;
  localparam int EN_PASS = 2;

  localparam logic [1:0] KIND_MAX  = 2'd0;
  localparam logic [1:0] KIND_MIN  = 2'd1;
  localparam logic [1:0] KIND_RISE = 2'd2;
  localparam logic [1:0] KIND_FALL = 2'd3;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] y_sample;
    logic signed [FIELD_BITS-1:0] x_value;
    logic                         end_of_vector;
  } in_item_t;

  typedef struct packed {
    logic                         is_summary;
    logic        [FIELD_BITS-1:0] event_index;
    logic signed [FIELD_BITS-1:0] event_x;
    logic signed [FIELD_BITS-1:0] event_y;
    logic        [1:0]            event_kind;
    logic        [COUNT_BITS-1:0] total_found;
    logic                         last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

// ----- hw/rtl/pkd_core.sv -----
module pkd_core
  import pkd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
  parameter int INDEX_BITS  = INDEX_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_item,
  input  logic [KIND_EN_BITS-1:0] kind_enable,
  input  logic [COUNT_BITS-1:0]   record_capacity,
  input  logic [1:0]              room,
  output push_t                   push
);

  logic                          in_full;
  in_item_t                      in_reg;
  logic                          accept;
  logic                          fire;

  logic        [INDEX_BITS-1:0]  sample_count;
  logic signed [SAMPLE_BITS-1:0] previous_distinct;
  logic                          have_previous;
  logic signed [SAMPLE_BITS-1:0] plateau_value;
  logic        [INDEX_BITS-1:0]  plateau_last_index;
  logic        [FIELD_BITS-1:0]  plateau_last_x;
  logic        [COUNT_BITS-1:0]  found_count;
  logic        [COUNT_BITS-1:0]  found_count_next;

  logic signed [SAMPLE_BITS-1:0] y_s;
  logic                          first_sample;
  logic                          closes;
  logic                          hit;
  logic        [1:0]             kind;
  logic                          found;
  logic                          emit;
  logic                          eov;
  logic        [1:0]             n_results;
  out_item_t                     rec;
  out_item_t                     summ;

  assign y_s          = SAMPLE_BITS'($signed(in_reg.y_sample));
  assign eov          = in_reg.end_of_vector;
  assign first_sample = (sample_count == '0);
  assign closes       = !first_sample && (y_s != plateau_value);

  always_comb begin
    hit  = 1'b1;
    kind = KIND_MAX;
    if (kind_enable[EN_MAX] && plateau_value > previous_distinct && plateau_value > y_s) begin
      kind = KIND_MAX;
    end else if (kind_enable[EN_MIN] && plateau_value < previous_distinct
                 && plateau_value < y_s) begin
      kind = KIND_MIN;
    end else if (kind_enable[EN_PASS] && plateau_value > previous_distinct
                 && y_s > plateau_value) begin
      kind = KIND_RISE;
    end else if (kind_enable[EN_PASS] && plateau_value < previous_distinct
                 && y_s < plateau_value) begin
      kind = KIND_FALL;
    end else begin
      hit = 1'b0;
    end
  end

  assign found = closes && have_previous && hit;
  assign emit  = found && (found_count < record_capacity);

  always_comb begin
    found_count_next = found_count;
    if (found && found_count != COUNT_MAX) begin
      found_count_next = found_count + 15'd1;
    end
  end

  always_comb begin
    rec             = '0;
    rec.event_index = FIELD_BITS'(plateau_last_index);
    rec.event_x     = plateau_last_x;
    rec.event_y     = FIELD_BITS'(plateau_value);
    rec.event_kind  = kind;
    rec.last_of_run = !eov;
    summ             = '0;
    summ.is_summary  = 1'b1;
    summ.total_found = found_count_next;
    summ.last_of_run = 1'b1;
  end

  assign n_results = {1'b0, emit} + {1'b0, eov};
  assign fire      = in_full && (n_results <= room);
  assign in_stall  = in_full && !fire;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    push        = '0;
    push.first  = emit ? rec : summ;
    push.second = summ;
    if (fire) begin
      push.count = n_results;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      have_previous <= 1'b0;
      found_count   <= '0;
    end else if (fire) begin
      if (eov) begin
        sample_count  <= '0;
        have_previous <= 1'b0;
        found_count   <= '0;
      end else begin
        if (sample_count != '1) begin
          sample_count <= sample_count + INDEX_BITS'(1);
        end
        if (first_sample) begin
          have_previous <= 1'b0;
        end else if (closes) begin
          have_previous <= 1'b1;
        end
        found_count <= found_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      plateau_value      <= y_s;
      plateau_last_index <= sample_count;
      plateau_last_x     <= in_reg.x_value;
      if (closes) begin
        previous_distinct <= plateau_value;
      end
    end
  end

endmodule

// ----- hw/rtl/pkd_outq.sv -----
module pkd_outq
  import pkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic [1:0] room,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  logic [1:0] cnt;
  logic [1:0] cnt_mid;
  logic       pop;
  out_item_t  q0;
  out_item_t  q1;
  out_item_t  s0;
  out_item_t  q0_next;
  out_item_t  q1_next;

  assign out_valid = (cnt != 2'd0);
  assign out_item  = q0;
  assign pop       = out_valid && !out_stall;
  assign cnt_mid   = cnt - {1'b0, pop};
  assign room      = 2'd2 - cnt_mid;
  assign s0        = pop ? q1 : q0;

  always_comb begin
    q0_next = s0;
    q1_next = q1;
    case (cnt_mid)
      2'd0: begin
        q0_next = push.first;
        q1_next = push.second;
      end
      2'd1: begin
        q1_next = push.first;
      end
      default: begin
        q1_next = q1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_mid + push.count;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

endmodule

// ----- hw/rtl/plateau_aware_peak_detector_unit.sv -----
// Plateau-aware peak detector. Takes one signed sample per transaction, merges runs of
// equal samples and reports each interior plateau that is a maximum, a minimum, or a
// rising or falling pass (as enabled in kind_enable) as an event record, up to
// record_capacity per vector, and ends every vector with a summary carrying the
// saturating event count. Throughput is one sample per cycle while the output queue has
// room for the sample's results: a sample is registered on acceptance, classified from
// that input register and its results land in a two-entry output queue, which registers
// them before they are offered. The single output port sets the rate: a final sample
// that also closes a recorded event yields two results, which leave the port in turn.
// Configuration writes take effect on the next cycle and belong between vectors.
`include "assert_macros.svh"

module plateau_aware_peak_detector_unit
  import pkd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
  parameter int INDEX_BITS  = INDEX_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_item,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [KIND_EN_BITS-1:0] kind_enable;
  logic [COUNT_BITS-1:0]   record_capacity;
  logic [1:0]              room;
  push_t                   push;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_enable     <= KIND_ENABLE_RESET;
      record_capacity <= COUNT_MAX;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KIND_ENABLE: begin
          kind_enable <= cfg_data[KIND_EN_BITS-1:0];
        end
        CFG_RECORD_CAPACITY: begin
          record_capacity <= cfg_data[COUNT_BITS-1:0];
        end
        default: begin
          kind_enable <= kind_enable;
        end
      endcase
    end
  end

  pkd_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .kind_enable    (kind_enable),
    .record_capacity(record_capacity),
    .room           (room),
    .push           (push)
  );

  pkd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  `PKD_ASSERT(a_push_fits, push.count <= room, "result push overflows the output queue")
  `PKD_ASSERT_IMPLY(a_pair_order, push.count == 2'd2,
    !push.first.is_summary && push.second.is_summary,
    "two results from one sample must be a record followed by the summary")
  `PKD_ASSERT_IMPLY(a_empty_no_stall, !out_valid, !in_stall,
    "input stalled while the output queue is empty")

endmodule
